/* rtl/tpe_pkg.sv */
package tpe_pkg;

  localparam int PACKET_BYTES = 45;
  localparam int POS_W = 6;

  localparam logic [1:0] FUNC_ROW    = 2'd0;
  localparam logic [1:0] FUNC_HEADER = 2'd1;
  localparam logic [1:0] FUNC_TEXT   = 2'd2;

  localparam logic [7:0] RUN_IN     = 8'h55;
  localparam logic [7:0] FRAMING    = 8'h27;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [6:0] CHAR_LF    = 7'h0a;
  localparam logic [7:0] CHAR_QUERY = 8'h3f;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [POS_W-1:0] POS_CLOSED      = POS_W'(PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_FINAL       = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] ROW_PREFIX_LAST = POS_W'(4);
  localparam logic [POS_W-1:0] HDR_PREFIX_LAST = POS_W'(12);

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  magazine;
    logic [4:0]  row_number;
    logic [7:0]  page_number;
    logic [12:0] subcode;
    logic [15:0] control;
    logic [7:0]  text_char;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       last;
    logic       pend;
  } beat_t;

  function automatic logic [7:0] ham84(input logic [3:0] nib);
    logic [7:0] r;
    case (nib)
      4'h0: r = 8'h15;
      4'h1: r = 8'h02;
      4'h2: r = 8'h49;
      4'h3: r = 8'h5e;
      4'h4: r = 8'h64;
      4'h5: r = 8'h73;
      4'h6: r = 8'h38;
      4'h7: r = 8'h2f;
      4'h8: r = 8'hd0;
      4'h9: r = 8'hc7;
      4'ha: r = 8'h8c;
      4'hb: r = 8'h9b;
      4'hc: r = 8'ha1;
      4'hd: r = 8'hb6;
      4'he: r = 8'hfd;
      4'hf: r = 8'hea;
      default: r = 8'h15;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] odd_par(input logic [7:0] c);
    return (^c[6:0]) ? {1'b0, c[6:0]} : {1'b1, c[6:0]};
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] c);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = c[7-i];
    end
    return r;
  endfunction

endpackage

/* rtl/teletext_packet_encoder.sv */
// an accepted item is held in the item register and its bytes go out through the output register
// throughput: one packet byte per cycle while out_ready does not stall the output; a text
// item gives one byte, a row start 5, a header start 13, a padding run up to 40; dropped
// items give none; bytes come from the single byte generator fed from the held item
// reset: output and item stages empty, no packet open, row packet mode
module teletext_packet_encoder import tpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [2:0]  magazine,
  input  logic [4:0]  row_number,
  input  logic [7:0]  page_number,
  input  logic [12:0] subcode,
  input  logic [15:0] control,
  input  logic [7:0]  text_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        packet_end
);

  item_t            item;
  logic             busy;
  logic [POS_W-1:0] pos;
  logic             is_header;
  beat_t            beat;
  logic             take;
  logic             advance;
  logic             done;
  logic             accept;

  tpe_byte_gen u_gen (
    .item      (item),
    .busy      (busy),
    .pos       (pos),
    .is_header (is_header),
    .beat      (beat)
  );

  tpe_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .packet_end  (packet_end)
  );

  // an item with nothing to send is done at once, without waiting on the output stage
  assign advance  = !beat.emit || take;
  assign done     = busy && advance && (!beat.emit || beat.last);
  assign in_ready = !busy || done;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= POS_CLOSED;
      is_header <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (accept && ((func == FUNC_ROW) || (func == FUNC_HEADER))) begin
        pos       <= '0;
        is_header <= (func == FUNC_HEADER);
      end else if (beat.emit && take) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.func        <= func;
      item.magazine    <= magazine;
      item.row_number  <= row_number;
      item.page_number <= page_number;
      item.subcode     <= subcode;
      item.control     <= control;
      item.text_char   <= text_char;
    end
  end

endmodule

/* rtl/tpe_byte_gen.sv */
module tpe_byte_gen import tpe_pkg::*; (
  input  item_t            item,
  input  logic             busy,
  input  logic [POS_W-1:0] pos,
  input  logic             is_header,
  output beat_t            beat
);

  logic       start;
  logic       hdr;
  logic [4:0] row;
  logic [7:0] prefix;
  logic [7:0] ch;
  logic       fill;
  logic [7:0] raw;

  always_comb begin
    start = (item.func == FUNC_ROW) || (item.func == FUNC_HEADER);
    hdr   = (item.func == FUNC_HEADER);
    row   = hdr ? 5'd0 : item.row_number;
    ch    = item.text_char;
    fill  = !is_header && ((ch == CHAR_CR) || (ch[6:0] == 7'd0));

    case (pos[3:0])
      4'd0, 4'd1: prefix = RUN_IN;
      4'd2:  prefix = FRAMING;
      4'd3:  prefix = ham84({row[0], item.magazine});
      4'd4:  prefix = ham84(row[4:1]);
      4'd5:  prefix = ham84(item.page_number[3:0]);
      4'd6:  prefix = ham84(item.page_number[7:4]);
      4'd7:  prefix = ham84(item.subcode[3:0]);
      4'd8:  prefix = ham84({item.control[14], item.subcode[6:4]});
      4'd9:  prefix = ham84(item.subcode[10:7]);
      4'd10: prefix = ham84({item.control[1], item.control[0], item.subcode[12:11]});
      4'd11: prefix = ham84(item.control[5:2]);
      4'd12: prefix = ham84(item.control[9:6]);
      default: prefix = RUN_IN;
    endcase

    beat = '0;
    raw  = prefix;
    if (busy && start) begin
      beat.emit = 1'b1;
      beat.last = (pos == (hdr ? HDR_PREFIX_LAST : ROW_PREFIX_LAST));
    end else if (busy && (item.func == FUNC_TEXT) && (pos < POS_CLOSED)) begin
      beat.emit = 1'b1;
      if (is_header) begin
        raw       = odd_par(ch);
        beat.last = 1'b1;
      end else if (fill) begin
        // rest of the row padded with spaces
        raw       = odd_par(CHAR_SPACE);
        beat.last = (pos == POS_FINAL);
      end else begin
        raw       = odd_par((ch[6:0] == CHAR_LF) ? CHAR_QUERY : ch);
        beat.last = 1'b1;
      end
    end
    beat.data = rev8(raw);
    beat.pend = (pos == POS_FINAL);
  end

endmodule

/* rtl/tpe_out_stage.sv */
module tpe_out_stage import tpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  beat_t      beat,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       packet_end
);

  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= beat.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.emit) begin
      out_byte    <= beat.data;
      last_of_run <= beat.last;
      packet_end  <= beat.pend;
    end
  end

endmodule

/* verif/tb_teletext_packet_encoder.sv */
module tb_teletext_packet_encoder;
  import tpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  localparam logic [7:0] HAMMING_TABLE [16] = '{
    8'h15, 8'h02, 8'h49, 8'h5e, 8'h64, 8'h73, 8'h38, 8'h2f,
    8'hd0, 8'hc7, 8'h8c, 8'h9b, 8'ha1, 8'hb6, 8'hfd, 8'hea
  };

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       pend;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_UNUSED;
  logic [2:0]  magazine = '0;
  logic [4:0]  row_number = '0;
  logic [7:0]  page_number = '0;
  logic [12:0] subcode = '0;
  logic [15:0] control = '0;
  logic [7:0]  text_char = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        packet_end;

  // encoder state as predicted
  int         open_pos = PACKET_BYTES;
  logic       header_open = 1'b0;
  wire_byte_t expected_bytes [$];

  bit no_gaps = 1'b0;
  int err_count = 0;
  int items_fed = 0;
  int items_dropped = 0;
  int bytes_checked = 0;
  int rows_opened = 0;
  int headers_opened = 0;

  teletext_packet_encoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .magazine    (magazine),
    .row_number  (row_number),
    .page_number (page_number),
    .subcode     (subcode),
    .control     (control),
    .text_char   (text_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .packet_end  (packet_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] hamming_byte(input logic [3:0] nib);
    return HAMMING_TABLE[nib];
  endfunction

  function automatic logic [7:0] with_odd_parity(input logic [7:0] c);
    int ones;
    ones = 0;
    for (int b = 0; b < 7; b++) begin
      ones += c[b];
    end
    return {~ones[0], c[6:0]};
  endfunction

  function automatic logic [7:0] bit_reversed(input logic [7:0] c);
    return {<<{c}};
  endfunction

  // works out the wire bytes for one accepted item and moves the packet state on
  task automatic encode_item(input item_t it, output int n_out);
    logic [7:0] raw [$];
    logic [4:0] r;
    logic [7:0] v;
    int first_pos;
    first_pos = 0;
    if (it.func == FUNC_ROW || it.func == FUNC_HEADER) begin
      r = (it.func == FUNC_HEADER) ? 5'd0 : it.row_number;
      raw.push_back(RUN_IN);
      raw.push_back(RUN_IN);
      raw.push_back(FRAMING);
      raw.push_back(hamming_byte({r[0], it.magazine}));
      raw.push_back(hamming_byte(r[4:1]));
      if (it.func == FUNC_HEADER) begin
        raw.push_back(hamming_byte(it.page_number[3:0]));
        raw.push_back(hamming_byte(it.page_number[7:4]));
        raw.push_back(hamming_byte(it.subcode[3:0]));
        raw.push_back(hamming_byte({it.control[14], it.subcode[6:4]}));
        raw.push_back(hamming_byte(it.subcode[10:7]));
        raw.push_back(hamming_byte({it.control[1], it.control[0], it.subcode[12:11]}));
        raw.push_back(hamming_byte(it.control[5:2]));
        raw.push_back(hamming_byte(it.control[9:6]));
        headers_opened++;
      end else begin
        rows_opened++;
      end
      open_pos = raw.size();
      header_open = (it.func == FUNC_HEADER);
    end else if (it.func == FUNC_TEXT && open_pos < PACKET_BYTES) begin
      first_pos = open_pos;
      if (header_open) begin
        raw.push_back(with_odd_parity(it.text_char));
      end else if (it.text_char != CHAR_CR && it.text_char[6:0] != 7'd0) begin
        v = (it.text_char[6:0] == CHAR_LF) ? CHAR_QUERY : it.text_char;
        raw.push_back(with_odd_parity(v));
      end else begin
        // carriage return or null closes the row with spaces
        repeat (PACKET_BYTES - open_pos) raw.push_back(with_odd_parity(CHAR_SPACE));
      end
      open_pos += raw.size();
    end
    foreach (raw[k]) begin
      expected_bytes.push_back('{code: bit_reversed(raw[k]),
                                 last: (k == raw.size() - 1),
                                 pend: (first_pos + k == PACKET_BYTES - 1)});
    end
    n_out = raw.size();
  endtask

  task automatic feed_item(input item_t it, output int n_out);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= it.func;
    magazine    <= it.magazine;
    row_number  <= it.row_number;
    page_number <= it.page_number;
    subcode     <= it.subcode;
    control     <= it.control;
    text_char   <= it.text_char;
    do @(posedge clk); while (!in_ready);
    encode_item(it, n_out);
    items_fed++;
    if (n_out == 0) items_dropped++;
  endtask

  function automatic item_t noise_item();
    item_t it;
    it = item_t'({$urandom, $urandom});
    return it;
  endfunction

  function automatic item_t row_item(input logic [2:0] mag, input logic [4:0] row);
    item_t it;
    it = noise_item();
    it.func = FUNC_ROW;
    it.magazine = mag;
    it.row_number = row;
    return it;
  endfunction

  function automatic item_t header_item(input logic [2:0] mag, input logic [7:0] page,
                                        input logic [12:0] sub, input logic [15:0] ctl);
    item_t it;
    it = noise_item();
    it.func = FUNC_HEADER;
    it.magazine = mag;
    it.page_number = page;
    it.subcode = sub;
    it.control = ctl;
    return it;
  endfunction

  function automatic item_t text_item(input logic [7:0] ch);
    item_t it;
    it = noise_item();
    it.func = FUNC_TEXT;
    it.text_char = ch;
    return it;
  endfunction

  task automatic drain_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic test_no_packet_open();
    item_t it;
    int n;
    feed_item(text_item(8'h41), n);
    feed_item(text_item(CHAR_CR), n);
    it = noise_item();
    it.func = FUNC_UNUSED;
    feed_item(it, n);
  endtask

  task automatic test_row_packets();
    int n;
    feed_item(row_item(3'd0, 5'd0), n);
    feed_item(text_item(8'h41), n);
    feed_item(text_item(8'h0a), n);
    feed_item(text_item(8'h8a), n);
    feed_item(text_item(8'hff), n);
    feed_item(text_item(CHAR_CR), n);
    feed_item(text_item(8'h42), n);
    feed_item(row_item(3'd7, 5'd31), n);
    feed_item(text_item(8'h00), n);
    feed_item(row_item(3'd5, 5'd1), n);
    feed_item(text_item(8'h80), n);
  endtask

  task automatic test_header_packets();
    int n;
    feed_item(header_item(3'd0, 8'h00, 13'h0000, 16'h0000), n);
    feed_item(text_item(CHAR_CR), n);
    feed_item(header_item(3'd7, 8'hff, 13'h1fff, 16'hffff), n);
    feed_item(text_item(8'h00), n);
    feed_item(text_item(8'h0a), n);
    feed_item(header_item(3'd2, 8'h5a, 13'h0aaa, 16'h4000), n);
  endtask

  task automatic test_restart_open_packet();
    int n;
    feed_item(row_item(3'd2, 5'd9), n);
    feed_item(text_item(8'h78), n);
    feed_item(header_item(3'd1, 8'h37, 13'h1555, 16'h0155), n);
    feed_item(text_item(8'h79), n);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 39))
      0:       return CHAR_CR;
      1:       return {$urandom_range(0, 1) == 1, 7'h0a};
      2:       return {$urandom_range(0, 1) == 1, 7'h00};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_random_packets(input int n_items);
    int sent;
    int len;
    int n;
    bit drained;
    sent = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        feed_item(noise_item(), n);
        sent++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          feed_item(header_item(3'($urandom), 8'($urandom), 13'($urandom),
                                16'($urandom)), n);
        end else begin
          feed_item(row_item(3'($urandom), 5'($urandom)), n);
        end
        sent++;
        // sometimes runs past the end of the packet
        len = $urandom_range(0, 45);
        repeat (len) begin
          feed_item(text_item(pick_char()), n);
          sent++;
        end
      end
      if (!drained && sent > n_items / 2) begin
        drain_output();
        drained = 1'b1;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin : sink_pacing
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_bytes
    wire_byte_t want;
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN) begin
          $display("unexpected beat: byte %h last %b end %b", out_byte, last_of_run,
                   packet_end);
        end
      end else begin
        want = expected_bytes.pop_front();
        if (want.code !== out_byte || want.last !== last_of_run || want.pend !== packet_end)
        begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("beat %0d: expected byte %h last %b end %b, got byte %h last %b end %b",
                     bytes_checked, want.code, want.last, want.pend, out_byte, last_of_run,
                     packet_end);
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_no_packet_open();
    test_row_packets();
    test_header_packets();
    test_restart_open_packet();
    test_random_packets(300);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      err_count++;
      $display("%0d expected beats never arrived", expected_bytes.size());
    end
    $display("fed %0d items (%0d dropped or ignored), opened %0d rows and %0d headers",
             items_fed, items_dropped, rows_opened, headers_opened);
    $display("checked %0d output bytes, %0d mismatches", bytes_checked, err_count);
    if (err_count == 0) begin
      $display("tb_teletext_packet_encoder OK");
    end else begin
      $display("tb_teletext_packet_encoder NOT OK");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout with %0d beats outstanding", expected_bytes.size());
    $display("tb_teletext_packet_encoder NOT OK");
    $finish;
  end

endmodule
